### rtl/ppr_pkg.sv
// Shared types and constants for the personalized PageRank push vertex store.
// Used by every module of the block; depends on nothing.

package ppr_pkg;

   // Operation codes carried in the kind field
   localparam logic [1:0] KIND_GATHER = 2'd0;
   localparam logic [1:0] KIND_PUSH   = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_GAIN_KEEP   = 2'd0;
   localparam logic [1:0] CSR_GAIN_SPREAD = 2'd1;
   localparam logic [1:0] CSR_EPSILON     = 2'd2;

   localparam logic [30:0] GAIN_KEEP_RESET   = 31'd21262214;
   localparam logic [30:0] GAIN_SPREAD_RESET = 31'd1052479610;
   localparam logic [31:0] EPSILON_RESET     = 32'd107;

   // Spread divider: 32 quotient bits, four per cycle
   localparam int DIV_Q_W       = 32;
   localparam int DIV_STEP_BITS = 4;
   localparam int DIV_STEPS     = DIV_Q_W / DIV_STEP_BITS;
   localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] vertex;
      logic [31:0] update_value;
      logic [23:0] vertex_degree;
   } req_type;

   typedef struct packed {
      logic        activated;
      logic [15:0] pushed_vertex;
      logic [31:0] spread_value;
      logic [31:0] estimate_value;
      logic [31:0] residual_value;
   } rsp_type;

   typedef struct packed {
      logic [31:0] estimate;
      logic [31:0] residual;
   } entry_type;

   typedef struct packed {
      logic        start;
      logic [33:0] dividend;
      logic [23:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

endpackage

### rtl/ppr_store.sv
// Vertex store: one synchronous memory of estimate/residual pairs,
// one write port, one read port with registered data. Uses ppr_pkg.

module ppr_store
   import ppr_pkg::*;
#(
   parameter int DEPTH  = 65536,
   parameter int ADDR_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  entry_type         wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type         rd_data
);

   entry_type mem_array [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_array[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ppr_divider.sv
// Iterative restoring divider for the spread value, DIV_STEP_BITS quotient
// bits per cycle, result saturated to 32 bits. Uses ppr_pkg.

module ppr_divider
   import ppr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [23:0]          divisor_ff;
   logic [23:0]          rem_ff;
   logic [DIV_Q_W-1:0]   quo_ff;
   logic [23:0]          rem_in;
   logic [DIV_Q_W-1:0]   quo_in;
   logic [24:0]          trial;

   // quo_ff shifts dividend bits out of the top and quotient bits in at the bottom
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      trial  = '0;
      for (int i = 0; i < DIV_STEP_BITS; i++) begin
         trial  = {rem_in, quo_in[DIV_Q_W-1]};
         quo_in = {quo_in[DIV_Q_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in    = 24'(trial - {1'b0, divisor_ff});
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial[23:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            divisor_ff <= div_req.divisor;
            // quotient of 2^32 or more: saturate at once
            if ({22'b0, div_req.dividend[33:32]} >= div_req.divisor) begin
               quo_ff  <= '1;
               done_ff <= 1'b1;
            end else begin
               rem_ff  <= {22'b0, div_req.dividend[33:32]};
               quo_ff  <= div_req.dividend[31:0];
               cnt_ff  <= DIV_CNT_W'(DIV_STEPS - 1);
               busy_ff <= 1'b1;
            end
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

### rtl/ppr_push_vertex_update.sv
// Personalized PageRank push vertex store: sequencer, shared multiplier,
// configuration and result register. Uses ppr_pkg, ppr_store, ppr_divider.
// Items are taken one at a time: a read passes ST_READ, ST_MUL1, ST_FIN; a gather adds
// ST_MUL2; a push adds ST_MUL2, ST_MUL3 and, for a nonzero degree, ST_DIV, waiting for
// the spread divider (four quotient bits a cycle). The next item is taken in the cycle
// after the result is loaded. A VERTEX_COUNT below 65536 that is not a power of two adds
// index reduction steps in ST_MOD. Reset: sync, active high; then a clearing pass
// zeroes the store with req_ready low (configuration writes are still taken).

module ppr_push_vertex_update
   import ppr_pkg::*;
#(
   parameter int VERTEX_COUNT = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int IDX_W = $clog2(VERTEX_COUNT);

   // largest k with VERTEX_COUNT << k inside the 16-bit vertex range
   function automatic int mod_top(input longint vc);
      int k;
      k = 0;
      for (int i = 0; i < 17; i++) begin
         if ((vc << i) <= 65535) begin
            k = i;
         end
      end
      return k;
   endfunction

   localparam bit NEED_MOD = (VERTEX_COUNT < 65536) &&
                             ((VERTEX_COUNT & (VERTEX_COUNT - 1)) != 0);
   localparam logic [4:0]  MOD_TOP  = 5'(mod_top(VERTEX_COUNT));
   localparam logic [16:0] MOD_BASE = 17'(VERTEX_COUNT);

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_MOD   = 4'd2;
   localparam logic [3:0] ST_READ  = 4'd3;
   localparam logic [3:0] ST_MUL1  = 4'd4;
   localparam logic [3:0] ST_MUL2  = 4'd5;
   localparam logic [3:0] ST_MUL3  = 4'd6;
   localparam logic [3:0] ST_DIV   = 4'd7;
   localparam logic [3:0] ST_FIN   = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic [IDX_W-1:0] clr_addr_ff;
   logic [4:0]       mod_cnt_ff;
   logic [15:0]      rem_ff;
   logic [16:0]      mod_sub;

   logic [30:0] gain_keep_ff;
   logic [30:0] gain_spread_ff;
   logic [31:0] epsilon_ff;

   logic [1:0]  kind_ff;
   logic [15:0] vertex_ff;
   logic [31:0] update_ff;
   logic [23:0] degree_ff;

   entry_type   ent_ff;
   logic [62:0] prod_ff;
   logic [33:0] gain_ff;
   logic [31:0] est_new_ff;
   logic [31:0] res_new_ff;
   logic        act_ff;
   logic [31:0] spread_ff;

   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   logic [IDX_W-1:0] idx;
   logic             is_gather, is_push;
   logic             rsp_load;
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   entry_type        mem_wr_data;
   entry_type        mem_rd_data;

   logic [31:0] mul_a;
   logic [30:0] mul_b;
   logic [62:0] mul_p;
   logic [32:0] gather_sum;
   logic [63:0] gain_rnd;
   logic [34:0] est_sum;
   logic [63:0] num_sum;

   div_req_type div_req;
   div_rsp_type div_rsp;

   assign idx       = IDX_W'(rem_ff);
   assign is_gather = (kind_ff == KIND_GATHER);
   assign is_push   = (kind_ff == KIND_PUSH);
   assign mod_sub   = MOD_BASE << mod_cnt_ff;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_load  = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);

   // Store accesses never overlap: an item's write lands before the next read.
   assign mem_wr_en   = (state_ff == ST_CLEAR) || (rsp_load && (is_gather || is_push));
   assign mem_wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : idx;
   assign mem_wr_data = (state_ff == ST_CLEAR) ? entry_type'('0)
                                               : entry_type'({est_new_ff, res_new_ff});

   ppr_store #(
      .DEPTH  (VERTEX_COUNT),
      .ADDR_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (idx),
      .rd_data (mem_rd_data)
   );

   // Shared multiplier: threshold on gather; keep gain, then spread gain on push
   always_comb begin
      mul_a = mem_rd_data.residual;
      mul_b = gain_keep_ff;
      if (state_ff == ST_MUL2) begin
         mul_a = ent_ff.residual;
         mul_b = gain_spread_ff;
      end else if (is_gather) begin
         mul_a = epsilon_ff;
         mul_b = {7'b0, degree_ff};
      end
   end

   assign mul_p      = {31'b0, mul_a} * {32'b0, mul_b};
   assign gather_sum = {1'b0, mem_rd_data.residual} + {1'b0, update_ff};
   assign gain_rnd   = {1'b0, prod_ff} + (64'd1 << 29);
   assign est_sum    = {3'b0, ent_ff.estimate} + {1'b0, gain_ff};
   assign num_sum    = {1'b0, prod_ff} + {11'b0, degree_ff, 29'b0};

   // Rounding offset folded in, then the Q-shift: floor(N / 2^30) / degree
   assign div_req.start    = (state_ff == ST_MUL3) && (degree_ff != '0);
   assign div_req.dividend = num_sum[63:30];
   assign div_req.divisor  = degree_ff;

   ppr_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == IDX_W'(VERTEX_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = NEED_MOD ? ST_MOD : ST_READ;
            end
         end
         ST_MOD: begin
            if (mod_cnt_ff == '0) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_MUL1;
         ST_MUL1: state_in = (is_gather || is_push) ? ST_MUL2 : ST_FIN;
         ST_MUL2: state_in = is_push ? ST_MUL3 : ST_FIN;
         ST_MUL3: state_in = (degree_ff != '0) ? ST_DIV : ST_FIN;
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         gain_keep_ff   <= GAIN_KEEP_RESET;
         gain_spread_ff <= GAIN_SPREAD_RESET;
         epsilon_ff     <= EPSILON_RESET;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_GAIN_KEEP:   gain_keep_ff   <= csr_wdata[30:0];
               CSR_GAIN_SPREAD: gain_spread_ff <= csr_wdata[30:0];
               CSR_EPSILON:     epsilon_ff     <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            kind_ff    <= req_data.kind;
            vertex_ff  <= req_data.vertex;
            update_ff  <= req_data.update_value;
            degree_ff  <= req_data.vertex_degree;
            rem_ff     <= req_data.vertex;
            mod_cnt_ff <= MOD_TOP;
         end
         ST_MOD: begin
            // reduce the vertex index by one shifted multiple of the depth
            if ({1'b0, rem_ff} >= mod_sub) begin
               rem_ff <= 16'({1'b0, rem_ff} - mod_sub);
            end
            mod_cnt_ff <= mod_cnt_ff - 1'b1;
         end
         ST_MUL1: begin
            ent_ff     <= mem_rd_data;
            prod_ff    <= mul_p;
            est_new_ff <= mem_rd_data.estimate;
            act_ff     <= 1'b0;
            spread_ff  <= '0;
            if (is_gather) begin
               res_new_ff <= gather_sum[32] ? '1 : gather_sum[31:0];
            end else begin
               res_new_ff <= mem_rd_data.residual;
            end
         end
         ST_MUL2: begin
            if (is_gather) begin
               act_ff <= ({31'b0, ent_ff.residual} < prod_ff) &&
                         (prod_ff < {31'b0, res_new_ff});
            end
            gain_ff <= gain_rnd[63:30];
            prod_ff <= mul_p;
         end
         ST_MUL3: begin
            est_new_ff <= (est_sum[34:32] != '0) ? '1 : est_sum[31:0];
            res_new_ff <= '0;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               spread_ff <= div_rsp.quotient;
            end
         end
         default: ;
      endcase
      if (rsp_load) begin
         rsp_data_ff.activated      <= act_ff;
         rsp_data_ff.pushed_vertex  <= vertex_ff;
         rsp_data_ff.spread_value   <= spread_ff;
         rsp_data_ff.estimate_value <= est_new_ff;
         rsp_data_ff.residual_value <= res_new_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_push_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && is_push) |-> (mem_wr_en && mem_wr_data.residual == '0))
      else $error("push did not clear the residual");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid && rsp_data.pushed_vertex == $past(vertex_ff)))
      else $error("loaded result not presented");

   a_div_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside its wait state");

endmodule

### tb/sv/tb_ppr_push_vertex_update.sv
// Self-checking testbench for ppr_push_vertex_update: drives gather, push, read and
// unused-kind items, predicts every result with a model of the vertex store and
// checks each one. Depends on ppr_pkg and the ppr_push_vertex_update RTL.
`timescale 1ns / 1ps

import ppr_pkg::*;

class VertexStoreScoreboard;
   localparam int VERTICES = 65536;

   bit [31:0] estimate_mem [VERTICES];
   bit [31:0] residual_mem [VERTICES];
   bit [30:0] keep_gain;
   bit [30:0] spread_gain;
   bit [31:0] epsilon;
   rsp_type   expected_q [$];
   int        mismatches;

   function new();
      keep_gain   = GAIN_KEEP_RESET;
      spread_gain = GAIN_SPREAD_RESET;
      epsilon     = EPSILON_RESET;
      mismatches  = 0;
   endfunction

   function void write_csr(logic [1:0] index, logic [31:0] value);
      case (index)
         CSR_GAIN_KEEP:   keep_gain   = value[30:0];
         CSR_GAIN_SPREAD: spread_gain = value[30:0];
         CSR_EPSILON:     epsilon     = value;
         default: ;
      endcase
   endfunction

   // Apply one accepted item to the store copy and queue the result it causes.
   function void note_item(req_type it);
      longint unsigned old_res, threshold, sum, gain, den, quo;
      rsp_type expd;
      int idx;
      idx = it.vertex;
      expd = '0;
      expd.pushed_vertex = it.vertex;
      case (it.kind)
         KIND_GATHER: begin
            old_res   = residual_mem[idx];
            threshold = longint'(epsilon) * longint'(it.vertex_degree);
            sum       = old_res + longint'(it.update_value);
            if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
            residual_mem[idx] = sum[31:0];
            expd.activated = (old_res < threshold) && (threshold < sum);
         end
         KIND_PUSH: begin
            old_res = residual_mem[idx];
            gain = (old_res * longint'(keep_gain) + (64'd1 << 29)) >> 30;
            sum  = longint'(estimate_mem[idx]) + gain;
            if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
            estimate_mem[idx] = sum[31:0];
            if (it.vertex_degree != 0) begin
               den = longint'(it.vertex_degree) << 30;
               quo = (old_res * longint'(spread_gain) + (den >> 1)) / den;
               if (quo > 64'hFFFF_FFFF) quo = 64'hFFFF_FFFF;
               expd.spread_value = quo[31:0];
            end
            residual_mem[idx] = '0;
         end
         default: ;
      endcase
      expd.estimate_value = estimate_mem[idx];
      expd.residual_value = residual_mem[idx];
      expected_q = {expected_q, expd};
   endfunction

   function void check_result(rsp_type got);
      rsp_type expd;
      bit bad;
      if (expected_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: unexpected result, vertex %0d", $realtime, got.pushed_vertex);
         return;
      end
      expd = expected_q.pop_front();
      bad = (got.activated != expd.activated) ||
            (got.pushed_vertex != expd.pushed_vertex) ||
            (got.spread_value != expd.spread_value) ||
            (got.estimate_value != expd.estimate_value) ||
            (got.residual_value != expd.residual_value);
      if (bad) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: result mismatch vertex %0d", $realtime, expd.pushed_vertex);
            $display("   exp act=%0d spread=%h est=%h res=%h", expd.activated,
                     expd.spread_value, expd.estimate_value, expd.residual_value);
            $display("   got act=%0d vtx=%0d spread=%h est=%h res=%h", got.activated,
                     got.pushed_vertex, got.spread_value, got.estimate_value,
                     got.residual_value);
         end
      end
   endfunction

   function int outstanding();
      return expected_q.size();
   endfunction
endclass

module tb_ppr_push_vertex_update;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [1:0] CSR_UNUSED  = 2'd3;
   localparam int STALL_LIMIT  = 200000;  // covers the clearing pass after reset
   localparam int DRAIN_CYCLES = 32;
   localparam int HOLD_CYCLES  = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   VertexStoreScoreboard sb = new();

   bit idling = 1'b1;
   bit pressure_req = 1'b0;
   int hold_left = 0;
   int stall_left = 0;
   int quiet_cycles = 0;

   ppr_push_vertex_update dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: check accepted items, then pick ready for the next edge.
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (pressure_req) begin
         pressure_req = 1'b0;
         hold_left = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 7) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic req_type mk_item(logic [1:0] kind, logic [15:0] vertex,
                                       logic [31:0] upd, logic [23:0] degree);
      req_type it;
      it.kind          = kind;
      it.vertex        = vertex;
      it.update_value  = upd;
      it.vertex_degree = degree;
      return it;
   endfunction

   // Mostly gathers on a few hot vertices so residuals build up and cross the threshold.
   function automatic req_type rand_item();
      req_type it;
      int sel;
      sel = $urandom_range(0, 19);
      if (sel < 11) it.kind = KIND_GATHER;
      else if (sel < 16) it.kind = KIND_PUSH;
      else if (sel < 19) it.kind = KIND_READ;
      else it.kind = KIND_UNUSED;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: it.vertex = 16'($urandom_range(0, 7));
         6:       it.vertex = 16'hFFF8 | 16'($urandom_range(0, 7));
         default: it.vertex = 16'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0:       it.update_value = '0;
         1:       it.update_value = '1;
         2, 3:    it.update_value = $urandom;
         4:       it.update_value = 32'($urandom & 32'h00FF_FFFF);
         default: it.update_value = 32'($urandom_range(0, 4000));
      endcase
      case ($urandom_range(0, 19))
         0:       it.vertex_degree = '0;
         1:       it.vertex_degree = '1;
         2, 3:    it.vertex_degree = 24'($urandom);
         default: it.vertex_degree = 24'($urandom_range(1, 64));
      endcase
      return it;
   endfunction

   task automatic send_item(req_type it);
      int gap;
      if (idling && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_item(it);
   endtask

   // Write all three registers back to back; optionally a stray index that must be ignored.
   task automatic program_csrs(logic [31:0] keep, logic [31:0] spread, logic [31:0] eps,
                               bit stray);
      logic [31:0] junk;
      junk = $urandom;
      csr_wr_en <= 1'b1;
      csr_index <= CSR_GAIN_KEEP;
      csr_wdata <= keep;
      @(posedge clock);
      sb.write_csr(CSR_GAIN_KEEP, keep);
      csr_index <= CSR_GAIN_SPREAD;
      csr_wdata <= spread;
      @(posedge clock);
      sb.write_csr(CSR_GAIN_SPREAD, spread);
      csr_index <= CSR_EPSILON;
      csr_wdata <= eps;
      @(posedge clock);
      sb.write_csr(CSR_EPSILON, eps);
      if (stray) begin
         csr_index <= CSR_UNUSED;
         csr_wdata <= junk;
         @(posedge clock);
         sb.write_csr(CSR_UNUSED, junk);
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid and wait until every expected result is back and the block is quiet.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(int count);
      repeat (count) send_item(rand_item());
      wait_drained();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset gains and threshold.
      send_item(mk_item(KIND_READ,   16'h0000, 32'h0, 24'h0));
      send_item(mk_item(KIND_GATHER, 16'h0000, 32'hFFFF_FFFF, 24'hFF_FFFF));
      send_item(mk_item(KIND_GATHER, 16'h0000, 32'hFFFF_FFFF, 24'h00_0001));
      send_item(mk_item(KIND_PUSH,   16'h0000, 32'h0, 24'h00_0001));
      send_item(mk_item(KIND_GATHER, 16'h0000, 32'h0, 24'h0));
      send_item(mk_item(KIND_GATHER, 16'hFFFF, 32'd1000, 24'd5));
      send_item(mk_item(KIND_PUSH,   16'hFFFF, 32'h1234_5678, 24'h0));
      send_item(mk_item(KIND_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 24'hFF_FFFF));
      send_item(mk_item(KIND_GATHER, 16'h0001, 32'h8000_0000, 24'h80_0000));
      send_item(mk_item(KIND_PUSH,   16'h0001, 32'h0, 24'hFF_FFFF));
      send_item(mk_item(KIND_PUSH,   16'h0001, 32'h0, 24'hFF_FFFF));
      // Landing exactly on the threshold, then starting exactly on it: no activation.
      send_item(mk_item(KIND_GATHER, 16'h0002, 32'd321, 24'd3));
      send_item(mk_item(KIND_GATHER, 16'h0002, 32'd1, 24'd3));
      send_item(mk_item(KIND_READ,   16'h0002, 32'h0, 24'h0));
      send_item(mk_item(KIND_GATHER, 16'h5555, 32'h5555_5555, 24'hAA_AAAA));
      send_item(mk_item(KIND_GATHER, 16'hAAAA, 32'hAAAA_AAAA, 24'h55_5555));
      send_item(mk_item(KIND_PUSH,   16'h5555, 32'h0, 24'h55_5555));
      send_item(mk_item(KIND_PUSH,   16'hAAAA, 32'h0, 24'hAA_AAAA));
      send_item(mk_item(KIND_UNUSED, 16'hAAAA, 32'h5555_5555, 24'h12_3456));
      wait_drained();

      // Unity gains, zero threshold.
      program_csrs(32'h4000_0000, 32'h4000_0000, 32'h0, 1'b1);
      send_item(mk_item(KIND_GATHER, 16'h0003, 32'hFFFF_FFFF, 24'h0));
      send_item(mk_item(KIND_PUSH,   16'h0003, 32'h0, 24'h00_0001));
      run_random(150);

      // Largest gains, top bit of the write data dropped; largest threshold.
      program_csrs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      repeat (4) begin
         send_item(mk_item(KIND_GATHER, 16'h0004, 32'hFFFF_FFFF, 24'h00_0001));
         send_item(mk_item(KIND_PUSH,   16'h0004, 32'h0, 24'h00_0001));
      end
      run_random(140);

      program_csrs(32'h0, 32'h0, 32'h1, 1'b1);
      run_random(100);

      // Reset values again, with the receiver holding off long enough to back up the input.
      program_csrs(32'(GAIN_KEEP_RESET), 32'(GAIN_SPREAD_RESET), EPSILON_RESET, 1'b0);
      pressure_req = 1'b1;
      run_random(250);

      repeat (2) begin
         program_csrs($urandom_range(0, 32'h7FFF_FFFF), $urandom_range(0, 32'h4000_0000),
                      $urandom_range(0, 100000), 1'b0);
         run_random(150);
      end

      // Closing stretch at full rate on both sides.
      idling = 1'b0;
      program_csrs($urandom_range(0, 32'h4000_0000), $urandom_range(0, 32'h4000_0000),
                   $urandom_range(0, 2000), 1'b0);
      run_random(180);

      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
